// ===== hdl/cad_pkg.sv =====
// Shared types, constants and small functions of the calendar date adder.
// Used by every module of the block; it depends on nothing else.
package cad_pkg;

  localparam int YearW    = 14;
  localparam int OffsetW  = 20;
  localparam int DaysW    = 23;
  localparam int CfgIdxW  = 1;
  localparam int InDataW  = 48;
  localparam int OutDataW = 24;

  localparam int ToDaysStages   = 4;
  localparam int FromDaysStages = 7;

  localparam int YearShift = 4000;
  localparam int EraDays   = 146097;

  localparam logic [YearW-1:0] YearMinRst = 14'd1902;
  localparam logic [YearW-1:0] YearMaxRst = 14'd2037;

  // Reciprocals for division by constants: q = (x * K) >> Sh, exact over the used range.
  localparam int Div100Sh  = 24;
  localparam logic [17:0] Div100K  = 18'(((64'd1 << Div100Sh) + 64'd99) / 64'd100);
  localparam int Div400Sh  = 24;
  localparam logic [15:0] Div400K  = 16'(((64'd1 << Div400Sh) + 64'd399) / 64'd400);
  localparam int DivEraSh  = 44;
  localparam logic [26:0] DivEraK  = 27'(((64'd1 << DivEraSh) + 64'd146096) / 64'd146097);
  localparam int Div1460Sh = 28;
  localparam logic [17:0] Div1460K = 18'(((64'd1 << Div1460Sh) + 64'd1459) / 64'd1460);
  localparam int Div365Sh  = 26;
  localparam logic [17:0] Div365K  = 18'(((64'd1 << Div365Sh) + 64'd364) / 64'd365);
  localparam int Div153Sh  = 20;
  localparam logic [12:0] Div153K  = 13'(((64'd1 << Div153Sh) + 64'd152) / 64'd153);

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_DATE = 2'd1,
    STATUS_RANGE    = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_YEAR_MIN = 1'b0,
    CFG_YEAR_MAX = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [4:0]                day;
    logic [3:0]                month;
    logic [YearW-1:0]          year;
    logic signed [OffsetW-1:0] offset;
  } date_in_t;

  typedef struct packed {
    logic             ok;
    logic [DaysW-1:0] z;
  } day_num_t;

  typedef struct packed {
    logic               ok;
    logic signed [15:0] year;
    logic [3:0]         month;
    logic [4:0]         day;
  } date_res_t;

  // Days from March 1 to the first day of a month counted from March.
  function automatic logic [8:0] days_before(input logic [3:0] mi);
    logic [8:0] r;
    case (mi)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // Quotient by 100 of a year within a 400-year era.
  function automatic logic [1:0] div100_small(input logic [8:0] v);
    logic [1:0] r;
    if (v >= 9'd300) r = 2'd3;
    else if (v >= 9'd200) r = 2'd2;
    else if (v >= 9'd100) r = 2'd1;
    else r = 2'd0;
    return r;
  endfunction

endpackage

// ===== hdl/cad_to_days.sv =====
// Input check and conversion of a date plus offset into a linear day number.
// Four register stages with per-stage valid bits; uses cad_pkg.
module cad_to_days import cad_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  date_in_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output day_num_t out_data_o
);

  logic [ToDaysStages-1:0] vld_q;
  logic [ToDaysStages-1:0] vld_in;
  logic [ToDaysStages:0]   rdy;

  always_comb begin
    rdy[ToDaysStages] = out_ready_i;
    for (int k = ToDaysStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld_q[ToDaysStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < ToDaysStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[ToDaysStages-1];

  // Stage 1: shifted March-based year, month index and the two reciprocal products.
  logic [14:0] ys_d;
  logic [3:0]  mi_d;
  logic        mok_d;
  logic [31:0] p100_d;
  logic [30:0] p400_d;

  always_comb begin
    ys_d   = 15'(in_data_i.year) + 15'(YearShift) - 15'(in_data_i.month <= 4'd2);
    mi_d   = (in_data_i.month > 4'd2) ? in_data_i.month - 4'd3 : in_data_i.month + 4'd9;
    mok_d  = (in_data_i.month >= 4'd1) && (in_data_i.month <= 4'd12);
    p100_d = 32'(in_data_i.year) * 32'(Div100K);
    p400_d = 31'(ys_d) * 31'(Div400K);
  end

  logic [4:0]                day1_q;
  logic [3:0]                month1_q;
  logic [YearW-1:0]          year1_q;
  logic signed [OffsetW-1:0] off1_q;
  logic [14:0]               ys1_q;
  logic [3:0]                mi1_q;
  logic                      mok1_q;
  logic [7:0]                q100_1_q;
  logic [5:0]                era1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      day1_q   <= in_data_i.day;
      month1_q <= in_data_i.month;
      year1_q  <= in_data_i.year;
      off1_q   <= in_data_i.offset;
      ys1_q    <= ys_d;
      mi1_q    <= mi_d;
      mok1_q   <= mok_d;
      q100_1_q <= p100_d[31:24];
      era1_q   <= p400_d[29:24];
    end
  end

  // Stage 2: leap rule, day-of-month check, year of era and day of year.
  logic [13:0] r100_d;
  logic        leap_d;
  logic [4:0]  mlen_d;
  logic        ok2_d;
  logic [8:0]  yoe2_d;
  logic [8:0]  doy2_d;

  always_comb begin
    r100_d = year1_q - 14'({6'b0, q100_1_q} * 14'd100);
    leap_d = ((year1_q[1:0] == 2'd0) && (r100_d != 14'd0)) ||
             ((r100_d == 14'd0) && (q100_1_q[1:0] == 2'd0));
    if (month1_q == 4'd2) begin
      mlen_d = leap_d ? 5'd29 : 5'd28;
    end else if (month1_q inside {4'd4, 4'd6, 4'd9, 4'd11}) begin
      mlen_d = 5'd30;
    end else begin
      mlen_d = 5'd31;
    end
    ok2_d  = mok1_q && (day1_q != 5'd0) && (day1_q <= mlen_d);
    yoe2_d = 9'(ys1_q - 15'({9'b0, era1_q} * 15'd400));
    doy2_d = days_before(mi1_q) + 9'(day1_q) - 9'd1;
  end

  logic                      ok2_q;
  logic [5:0]                era2_q;
  logic [8:0]                yoe2_q;
  logic [8:0]                doy2_q;
  logic signed [OffsetW-1:0] off2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      ok2_q  <= ok2_d;
      era2_q <= era1_q;
      yoe2_q <= yoe2_d;
      doy2_q <= doy2_d;
      off2_q <= off1_q;
    end
  end

  // Stage 3: day of era and days of the whole eras.
  logic [17:0]      doe3_d;
  logic [DaysW-1:0] ed3_d;

  always_comb begin
    doe3_d = 18'(yoe2_q) * 18'd365 + 18'(yoe2_q[8:2]) - 18'(div100_small(yoe2_q))
           + 18'(doy2_q);
    ed3_d  = DaysW'(era2_q) * DaysW'(EraDays);
  end

  logic                      ok3_q;
  logic [17:0]               doe3_q;
  logic [DaysW-1:0]          ed3_q;
  logic signed [OffsetW-1:0] off3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      ok3_q  <= ok2_q;
      doe3_q <= doe3_d;
      ed3_q  <= ed3_d;
      off3_q <= off2_q;
    end
  end

  // Stage 4: add the signed offset; the sum is always positive and below 2^23.
  logic [DaysW:0] z4_d;

  always_comb begin
    z4_d = {1'b0, ed3_q} + {6'b0, doe3_q} + {{(DaysW + 1 - OffsetW){off3_q[OffsetW-1]}}, off3_q};
  end

  day_num_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      out_q.ok <= ok3_q;
      out_q.z  <= z4_d[DaysW-1:0];
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/cad_from_days.sv =====
// Conversion of a linear day number back into year, month and day.
// Seven register stages with per-stage valid bits; uses cad_pkg.
module cad_from_days import cad_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  day_num_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output date_res_t out_data_o
);

  logic [FromDaysStages-1:0] vld_q;
  logic [FromDaysStages-1:0] vld_in;
  logic [FromDaysStages:0]   rdy;

  always_comb begin
    rdy[FromDaysStages] = out_ready_i;
    for (int k = FromDaysStages - 1; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
  end

  assign vld_in = {vld_q[FromDaysStages-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < FromDaysStages; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_in[k];
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = vld_q[FromDaysStages-1];

  // Stage 1: era number by reciprocal multiplication.
  logic [49:0] pe_d;
  assign pe_d = 50'(in_data_i.z) * 50'(DivEraK);

  logic             ok1_q;
  logic [DaysW-1:0] z1_q;
  logic [5:0]       era1_q;

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      ok1_q  <= in_data_i.ok;
      z1_q   <= in_data_i.z;
      era1_q <= pe_d[49:44];
    end
  end

  // Stage 2: day of era.
  logic [17:0] doe2_d;
  assign doe2_d = 18'(z1_q - DaysW'(era1_q) * DaysW'(EraDays));

  logic        ok2_q;
  logic [5:0]  era2_q;
  logic [17:0] doe2_q;

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      ok2_q  <= ok1_q;
      era2_q <= era1_q;
      doe2_q <= doe2_d;
    end
  end

  // Stage 3: leap-day corrections within the era.
  logic [35:0] p1460_d;
  logic [2:0]  cen_d;
  logic        top_d;

  always_comb begin
    p1460_d = 36'(doe2_q) * 36'(Div1460K);
    cen_d   = 3'(doe2_q >= 18'd36524) + 3'(doe2_q >= 18'd73048)
            + 3'(doe2_q >= 18'd109572) + 3'(doe2_q >= 18'd146096);
    top_d   = (doe2_q == 18'd146096);
  end

  logic        ok3_q;
  logic [5:0]  era3_q;
  logic [17:0] doe3_q;
  logic [6:0]  q1460_3_q;
  logic [2:0]  cen3_q;
  logic        top3_q;

  always_ff @(posedge clk_i) begin
    if (rdy[2]) begin
      ok3_q     <= ok2_q;
      era3_q    <= era2_q;
      doe3_q    <= doe2_q;
      q1460_3_q <= p1460_d[34:28];
      cen3_q    <= cen_d;
      top3_q    <= top_d;
    end
  end

  // Stage 4: year of era.
  logic [17:0] t4_d;
  logic [35:0] p365_d;

  always_comb begin
    t4_d   = doe3_q - 18'(q1460_3_q) + 18'(cen3_q) - 18'(top3_q);
    p365_d = 36'(t4_d) * 36'(Div365K);
  end

  logic        ok4_q;
  logic [5:0]  era4_q;
  logic [17:0] doe4_q;
  logic [8:0]  yoe4_q;

  always_ff @(posedge clk_i) begin
    if (rdy[3]) begin
      ok4_q  <= ok3_q;
      era4_q <= era3_q;
      doe4_q <= doe3_q;
      yoe4_q <= p365_d[34:26];
    end
  end

  // Stage 5: day of the March-based year.
  logic [8:0] doy5_d;
  assign doy5_d = 9'(doe4_q - (18'(yoe4_q) * 18'd365 + 18'(yoe4_q[8:2])
                              - 18'(div100_small(yoe4_q))));

  logic       ok5_q;
  logic [5:0] era5_q;
  logic [8:0] yoe5_q;
  logic [8:0] doy5_q;

  always_ff @(posedge clk_i) begin
    if (rdy[4]) begin
      ok5_q  <= ok4_q;
      era5_q <= era4_q;
      yoe5_q <= yoe4_q;
      doy5_q <= doy5_d;
    end
  end

  // Stage 6: month index from the day of year.
  logic [10:0] v6_d;
  logic [23:0] p153_d;

  always_comb begin
    v6_d   = 11'(doy5_q) * 11'd5 + 11'd2;
    p153_d = 24'(v6_d) * 24'(Div153K);
  end

  logic       ok6_q;
  logic [5:0] era6_q;
  logic [8:0] yoe6_q;
  logic [8:0] doy6_q;
  logic [3:0] mp6_q;

  always_ff @(posedge clk_i) begin
    if (rdy[5]) begin
      ok6_q  <= ok5_q;
      era6_q <= era5_q;
      yoe6_q <= yoe5_q;
      doy6_q <= doy5_q;
      mp6_q  <= p153_d[23:20];
    end
  end

  // Stage 7: calendar month, day and signed year.
  date_res_t res_d;

  always_comb begin
    res_d.ok    = ok6_q;
    res_d.day   = 5'(doy6_q - days_before(mp6_q) + 9'd1);
    res_d.month = (mp6_q < 4'd10) ? mp6_q + 4'd3 : mp6_q - 4'd9;
    res_d.year  = signed'(16'(yoe6_q) + 16'(era6_q) * 16'd400
                          + 16'(res_d.month <= 4'd2) - 16'(YearShift));
  end

  date_res_t out_q;

  always_ff @(posedge clk_i) begin
    if (rdy[6]) begin
      out_q <= res_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== hdl/calendar_date_add_days_core.sv =====
// Gregorian date adder: date plus signed day offset, with year limit check.
// An accepted input beat goes through 4 stages of day-number conversion,
// 7 stages of date recovery and one output register. Throughput is one beat
// per cycle unless the output stalls; a stall holds only stages with a beat.
// Reset clears all valid bits and sets the year limits to 1902 and 2037.
module calendar_date_add_days_core import cad_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [YearW-1:0]    cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // day[4:0], month[8:5], year[22:9], day_offset[42:23], zero padding[47:43]
  input  logic [InDataW-1:0]  s_axis_tdata,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // result_day[4:0], result_month[8:5], result_year[22:9], zero padding[23]
  output logic [OutDataW-1:0] m_axis_tdata,
  // status[1:0]
  output logic [1:0]          m_axis_tuser
);

  logic [YearW-1:0] year_min_q;
  logic [YearW-1:0] year_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      year_min_q <= YearMinRst;
      year_max_q <= YearMaxRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_YEAR_MIN: year_min_q <= cfg_wdata_i;
        CFG_YEAR_MAX: year_max_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  date_in_t in_beat;

  always_comb begin
    in_beat.day    = s_axis_tdata[4:0];
    in_beat.month  = s_axis_tdata[8:5];
    in_beat.year   = s_axis_tdata[22:9];
    in_beat.offset = signed'(s_axis_tdata[42:23]);
  end

  logic      dn_valid;
  logic      dn_ready;
  day_num_t  dn_data;
  logic      res_valid;
  logic      res_ready;
  date_res_t res_data;

  cad_to_days u_to_days (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_beat),
    .out_valid_o (dn_valid),
    .out_ready_i (dn_ready),
    .out_data_o  (dn_data)
  );

  cad_from_days u_from_days (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (dn_valid),
    .in_ready_o  (dn_ready),
    .in_data_i   (dn_data),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_data)
  );

  status_e          status_d;
  logic [4:0]       day_d;
  logic [3:0]       month_d;
  logic [YearW-1:0] year_d;

  always_comb begin
    if (!res_data.ok) begin
      status_d = STATUS_BAD_DATE;
    end else if ((res_data.year < 16'sd0) ||
                 (res_data.year < signed'({2'b00, year_min_q})) ||
                 (res_data.year > signed'({2'b00, year_max_q}))) begin
      status_d = STATUS_RANGE;
    end else begin
      status_d = STATUS_OK;
    end
    if (status_d == STATUS_OK) begin
      day_d   = res_data.day;
      month_d = res_data.month;
      year_d  = res_data.year[YearW-1:0];
    end else begin
      day_d   = '0;
      month_d = '0;
      year_d  = '0;
    end
  end

  logic             out_vld_q;
  status_e          status_q;
  logic [4:0]       day_q;
  logic [3:0]       month_q;
  logic [YearW-1:0] year_q;

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_ready) begin
      out_vld_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready) begin
      status_q <= status_d;
      day_q    <= day_d;
      month_q  <= month_d;
      year_q   <= year_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, year_q, month_q, day_q};
  assign m_axis_tuser  = status_q;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && (m_axis_tuser != STATUS_OK)) |-> (m_axis_tdata == '0))
    else $error("error beat carries a nonzero date");

  a_ok_date: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (m_axis_tvalid && (m_axis_tuser == STATUS_OK)) |->
      ((m_axis_tdata[8:5] >= 4'd1) && (m_axis_tdata[8:5] <= 4'd12) &&
       (m_axis_tdata[4:0] >= 5'd1)))
    else $error("ok beat carries an impossible month or day");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
      !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled while the output register is empty");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for calendar_date_add_days_core: streams start dates
// with day offsets, predicts each result date in SystemVerilog and compares.
// Depends on cad_pkg and the core RTL only.
module tb import cad_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int PipeLatency = ToDaysStages + FromDaysStages + 1;
  localparam int StallLimit  = 1000;
  localparam int HoldCycles  = 200;
  localparam int MaxYear     = (1 << YearW) - 1;

  typedef struct packed {
    logic [4:0]       day;
    logic [3:0]       month;
    logic [YearW-1:0] year;
    status_e          status;
  } exp_res_t;

  logic                clk_i;
  logic                rst_ni         = 1'b0;
  logic                cfg_we_i       = 1'b0;
  cfg_idx_e            cfg_idx_i      = CFG_YEAR_MIN;
  logic [YearW-1:0]    cfg_wdata_i    = '0;
  logic                s_axis_tvalid  = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata   = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready  = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  logic [YearW-1:0] lim_year_min = YearMinRst;
  logic [YearW-1:0] lim_year_max = YearMaxRst;
  exp_res_t         pending_results[$];
  exp_res_t         want;
  int               err_cnt       = 0;
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  int unsigned      hold_req      = 0;
  int unsigned      hold_ack      = 0;
  int unsigned      hold_left     = 0;

  calendar_date_add_days_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int days_in_month(input longint m, input longint y);
    if (m == 2) begin
      return (((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0)) ? 29 : 28;
    end
    if (m == 4 || m == 6 || m == 9 || m == 11) begin
      return 30;
    end
    return 31;
  endfunction

  // Day numbers count from March 1 of a year shifted far enough back that
  // every reachable date has a positive count.
  function automatic exp_res_t add_days_to_date(input date_in_t it);
    exp_res_t r;
    longint   y, m, d, z, era, yoe, doy, doe, mp;
    r = '0;
    r.status = STATUS_OK;
    if (it.month < 1 || it.month > 12 || it.day < 1 ||
        it.day > days_in_month(it.month, it.year)) begin
      r.status = STATUS_BAD_DATE;
      return r;
    end
    y = longint'(it.year) + YearShift;
    m = it.month;
    if (m <= 2) y = y - 1;
    era = y / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + longint'(it.day) - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    z = era * EraDays + doe + longint'(it.offset);

    era = z / EraDays;
    doe = z - era * EraDays;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    d = doy - (153 * mp + 2) / 5 + 1;
    m = mp < 10 ? mp + 3 : mp - 9;
    y = yoe + era * 400 - YearShift;
    if (m <= 2) y = y + 1;

    if (y < 0 || y < longint'(lim_year_min) || y > longint'(lim_year_max)) begin
      r.status = STATUS_RANGE;
      return r;
    end
    r.day   = d[4:0];
    r.month = m[3:0];
    r.year  = y[YearW-1:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    date_in_t acc;
    if (s_axis_tvalid && s_axis_tready) begin
      acc.day    = s_axis_tdata[4:0];
      acc.month  = s_axis_tdata[8:5];
      acc.year   = s_axis_tdata[22:9];
      acc.offset = s_axis_tdata[42:23];
      pending_results.push_back(add_days_to_date(acc));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result beat with no date pending: tdata %h tuser %h",
                 m_axis_tdata, m_axis_tuser);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata[4:0] !== want.day) begin
            $error("result_day: expected %0d, got %0d", want.day, m_axis_tdata[4:0]);
            err_cnt++;
          end
          if (m_axis_tdata[8:5] !== want.month) begin
            $error("result_month: expected %0d, got %0d", want.month, m_axis_tdata[8:5]);
            err_cnt++;
          end
          if (m_axis_tdata[22:9] !== want.year) begin
            $error("result_year: expected %0d, got %0d", want.year, m_axis_tdata[22:9]);
            err_cnt++;
          end
          if (m_axis_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
            err_cnt++;
          end
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack      <= hold_req;
        hold_left     <= HoldCycles;
        m_axis_tready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left     <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int stuck;
    stuck = 0;
    while (stuck < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck = 0;
      end else begin
        stuck++;
      end
    end
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_date(input date_in_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, it.offset, it.year, it.month, it.day};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_ymd(input int y, input int m, input int d, input int off);
    date_in_t it;
    it.day    = 5'(d);
    it.month  = 4'(m);
    it.year   = YearW'(y);
    it.offset = OffsetW'(off);
    send_date(it);
  endtask

  task automatic wait_all_results();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
    @(posedge clk_i);
  endtask

  task automatic set_limits(input int lo, input int hi);
    wait_all_results();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_YEAR_MIN;
    cfg_wdata_i <= YearW'(lo);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_YEAR_MAX;
    cfg_wdata_i <= YearW'(hi);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    lim_year_min = YearW'(lo);
    lim_year_max = YearW'(hi);
    @(posedge clk_i);
  endtask

  function automatic date_in_t rand_date();
    date_in_t it;
    int       pick, lo, hi, len;
    pick = $urandom_range(99);
    it.day    = 5'($urandom);
    it.month  = 4'($urandom);
    it.year   = YearW'($urandom);
    it.offset = OffsetW'($urandom);
    if (pick >= 12) begin
      lo = (lim_year_min < lim_year_max) ? int'(lim_year_min) : int'(lim_year_max);
      hi = (lim_year_min < lim_year_max) ? int'(lim_year_max) : int'(lim_year_min);
      lo = (lo < 30) ? 0 : lo - 30;
      hi = (hi > MaxYear - 30) ? MaxYear : hi + 30;
      it.month = 4'($urandom_range(12, 1));
      if (pick >= 20) it.year = YearW'($urandom_range(hi, lo));
      len = days_in_month(it.month, it.year);
      it.day = (pick < 40) ? 5'(len) : 5'($urandom_range(len, 1));
      case ($urandom_range(3))
        0: it.offset = OffsetW'(int'($urandom_range(800)) - 400);
        1: it.offset = OffsetW'(int'($urandom_range(80000)) - 40000);
        2: it.offset = OffsetW'(int'($urandom_range(6)) - 3);
        default: ;
      endcase
    end
    return it;
  endfunction

  task automatic test_date_validation();
    send_ymd(2024, 2, 29, 0);
    send_ymd(2023, 2, 29, 0);
    send_ymd(1900, 2, 29, 0);
    send_ymd(2000, 2, 29, 0);
    send_ymd(2023, 2, 0, 5);
    send_ymd(2023, 4, 0, 5);
    send_ymd(2023, 4, 31, 0);
    send_ymd(2023, 4, 30, 1);
    send_ymd(2023, 12, 31, 1);
    send_ymd(2024, 1, 1, -1);
    send_ymd(2023, 0, 15, 0);
    send_ymd(2023, 13, 15, 0);
    send_ymd(MaxYear, 15, 31, -1);
    send_ymd(2023, 1, 31, 0);
    send_ymd(1970, 1, 1, 524287);
    send_ymd(2037, 12, 31, -524288);
    send_ymd(1902, 1, 1, -1);
    send_ymd(2037, 12, 31, 1);
    wait_all_results();
  endtask

  task automatic test_year_limits();
    set_limits(0, MaxYear);
    send_ymd(0, 1, 1, -1);
    send_ymd(0, 3, 1, -1);
    send_ymd(MaxYear, 12, 31, 0);
    send_ymd(MaxYear, 12, 31, 1);
    send_ymd(0, 1, 1, 524287);
    send_ymd(MaxYear, 12, 31, -524288);
    set_limits(2000, 1999);
    send_ymd(2000, 1, 1, 0);
    send_ymd(2000, 2, 30, 0);
    wait_all_results();
  endtask

  task automatic test_random_dates();
    int lo;
    for (int ph = 0; ph < 3; ph++) begin
      wait_all_results();
      send_idle_pct  = (ph == 0) ? 32 : (ph == 1) ? 66 : 0;
      recv_idle_pct <= (ph == 0) ? 66 : (ph == 1) ? 32 : 0;
      for (int k = 0; k < 4; k++) begin
        lo = $urandom_range(MaxYear - 400);
        case (k)
          0: set_limits(YearMinRst, YearMaxRst);
          1: set_limits(0, MaxYear);
          2: set_limits(lo, lo + $urandom_range(400));
          default: begin
            if (ph == 1) set_limits(lo, lo);
            else set_limits(lo + $urandom_range(50, 1), lo);
          end
        endcase
        repeat (95) send_date(rand_date());
      end
    end
    wait_all_results();
  endtask

  // The receiver stalls long enough for the pipeline to fill and push back
  // on the input while the sender keeps offering beats.
  task automatic test_output_backpressure();
    set_limits(0, MaxYear);
    send_idle_pct  = 0;
    recv_idle_pct <= 0;
    hold_req      <= hold_req + 1;
    repeat (48) send_date(rand_date());
    wait_all_results();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_date_validation();
    test_year_limits();
    test_random_dates();
    test_output_backpressure();
    repeat (2 * PipeLatency) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d result dates never arrived", pending_results.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
